### rtl/chtbb_pkg.sv
// shared types and constants of the cascaded holt trend bass boost
package chtbb_pkg;

   // fixed formats of the stage state and of the configuration registers
   localparam int STATE_BITS     = 40;
   localparam int HEADROOM_BITS  = 8;
   localparam int GAIN_SHIFT     = 16;
   localparam int COEF_REG_BITS  = 24;
   localparam int GAIN_REG_BITS  = 17;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 2;

   // the 0.999 keep factor as a ratio
   localparam longint KEEP_NUM = 999;
   localparam longint KEEP_DEN = 1000;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_COEF = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TREND_COEF = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_GAIN = 2'd2;

   // product terms worked by the shared multiplier
   typedef enum logic [2:0] {
      TERM_TREND_DIFF,
      TERM_TREND_CARRY,
      TERM_LEVEL_IN,
      TERM_LEVEL_CARRY,
      TERM_WET
   } term_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SETUP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ROUND,
      ST_ACCUM,
      ST_SAT_TREND,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic     load_sample;
      logic     load_state;
      logic     setup;
      logic     mul_lo;
      logic     mul_hi;
      logic     round;
      logic     accum;
      logic     sat_trend;
      logic     commit;
      logic     finish;
      term_type term;
   } cmd_type;

endpackage

### rtl/chtbb_ctrl.sv
// sequencer that steps the shared multiplier through stages and terms
module chtbb_ctrl #(
   parameter int STAGES = 8,
   localparam int STAGE_IDX_BITS = (STAGES > 1) ? $clog2(STAGES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output chtbb_pkg::cmd_type        cmd,
   output logic [STAGE_IDX_BITS-1:0] stage_idx
);

   localparam logic [STAGE_IDX_BITS-1:0] LAST_STAGE = STAGE_IDX_BITS'(STAGES - 1);

   chtbb_pkg::state_type      state_ff, state_in;
   chtbb_pkg::term_type       term_ff, term_in;
   logic [STAGE_IDX_BITS-1:0] stage_ff, stage_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chtbb_pkg::ST_IDLE;
         term_ff      <= chtbb_pkg::TERM_TREND_DIFF;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      stage_in     = stage_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.term     = term_ff;
      unique case (state_ff)
         chtbb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               stage_in        = '0;
               term_in         = chtbb_pkg::TERM_TREND_DIFF;
               state_in        = chtbb_pkg::ST_LOAD;
            end
         end
         chtbb_pkg::ST_LOAD: begin
            cmd.load_state = 1'b1;
            state_in       = chtbb_pkg::ST_SETUP;
         end
         chtbb_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = chtbb_pkg::ST_MUL_LO;
         end
         chtbb_pkg::ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = chtbb_pkg::ST_MUL_HI;
         end
         chtbb_pkg::ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = chtbb_pkg::ST_ROUND;
         end
         chtbb_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = chtbb_pkg::ST_ACCUM;
         end
         chtbb_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            unique case (term_ff)
               chtbb_pkg::TERM_TREND_DIFF: begin
                  term_in  = chtbb_pkg::TERM_TREND_CARRY;
                  state_in = chtbb_pkg::ST_SETUP;
               end
               chtbb_pkg::TERM_TREND_CARRY: state_in = chtbb_pkg::ST_SAT_TREND;
               chtbb_pkg::TERM_LEVEL_IN: begin
                  term_in  = chtbb_pkg::TERM_LEVEL_CARRY;
                  state_in = chtbb_pkg::ST_SETUP;
               end
               chtbb_pkg::TERM_LEVEL_CARRY: state_in = chtbb_pkg::ST_COMMIT;
               chtbb_pkg::TERM_WET:         state_in = chtbb_pkg::ST_FINISH;
               default:                     state_in = chtbb_pkg::ST_IDLE;
            endcase
         end
         chtbb_pkg::ST_SAT_TREND: begin
            cmd.sat_trend = 1'b1;
            term_in       = chtbb_pkg::TERM_LEVEL_IN;
            state_in      = chtbb_pkg::ST_SETUP;
         end
         chtbb_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (stage_ff == LAST_STAGE) begin
               term_in  = chtbb_pkg::TERM_WET;
               state_in = chtbb_pkg::ST_SETUP;
            end else begin
               stage_in = stage_ff + 1'b1;
               term_in  = chtbb_pkg::TERM_TREND_DIFF;
               state_in = chtbb_pkg::ST_LOAD;
            end
         end
         chtbb_pkg::ST_FINISH: begin
            // wait here while the previous result is still unclaimed
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = chtbb_pkg::ST_IDLE;
            end
         end
         default: state_in = chtbb_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign stage_idx = stage_ff;

endmodule

### rtl/chtbb_datapath.sv
// stage state, config registers, shared split multiplier and rounding
module chtbb_datapath #(
   parameter int STAGES      = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 24,
   localparam int STAGE_IDX_BITS = (STAGES > 1) ? $clog2(STAGES) : 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  chtbb_pkg::cmd_type                      cmd,
   input  logic [STAGE_IDX_BITS-1:0]               stage_idx,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_in,
   output logic signed [SAMPLE_BITS-1:0]           rsp_sample_out,
   input  logic                                    csr_wr_en,
   input  logic [chtbb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [chtbb_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int SB         = chtbb_pkg::STATE_BITS;
   localparam int EXTRA_FRAC = SB - SAMPLE_BITS - chtbb_pkg::HEADROOM_BITS;
   localparam int WET_SHIFT  = chtbb_pkg::GAIN_SHIFT + EXTRA_FRAC;
   localparam int MIN_SHIFT  = (COEF_BITS < WET_SHIFT) ? COEF_BITS : WET_SHIFT;
   localparam int A_BITS     = SB + 2;
   localparam int A_MAG_BITS = SB + 1;
   localparam int A_LO_BITS  = (A_MAG_BITS + 1) / 2;
   localparam int A_HI_BITS  = A_MAG_BITS - A_LO_BITS;
   localparam int C_BITS     = COEF_BITS + 2;
   localparam int C_MAG_BITS = COEF_BITS + 1;
   localparam int PROD_BITS  = A_LO_BITS + C_MAG_BITS;
   localparam int ACC_BITS   = A_MAG_BITS + C_MAG_BITS + 1;
   localparam int Q_BITS     = ACC_BITS - MIN_SHIFT;
   localparam int SUM_BITS   = Q_BITS + 2;
   localparam int OUT_BITS   = SUM_BITS + 1;
   localparam int COEF_USED  =
      (COEF_BITS < chtbb_pkg::COEF_REG_BITS) ? COEF_BITS : chtbb_pkg::COEF_REG_BITS;
   localparam longint K_VALUE =
      ((longint'(1) << COEF_BITS) * chtbb_pkg::KEEP_NUM + chtbb_pkg::KEEP_DEN / 2)
      / chtbb_pkg::KEEP_DEN;
   localparam logic signed [C_BITS-1:0] K_COEF = C_BITS'(K_VALUE);
   localparam logic [ACC_BITS-1:0] R_COEF = ACC_BITS'(1) << (COEF_BITS - 1);
   localparam logic [ACC_BITS-1:0] R_WET  = ACC_BITS'(1) << (WET_SHIFT - 1);
   localparam logic signed [SUM_BITS-1:0] STATE_MAX =
      {{(SUM_BITS - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] STATE_MIN = ~STATE_MAX;
   localparam logic signed [OUT_BITS-1:0] SAMPLE_MAX =
      {{(OUT_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

   // configuration registers
   logic [chtbb_pkg::COEF_REG_BITS-1:0] level_coef_ff, level_coef_in;
   logic [chtbb_pkg::COEF_REG_BITS-1:0] trend_coef_ff, trend_coef_in;
   logic [chtbb_pkg::GAIN_REG_BITS-1:0] boost_gain_ff, boost_gain_in;

   // stage state
   logic signed [SB-1:0] level_mem_ff [STAGES];
   logic signed [SB-1:0] trend_mem_ff [STAGES];

   // working registers
   logic signed [SAMPLE_BITS-1:0] dry_ff, dry_in;
   logic signed [SB-1:0]          x_ff, x_in;
   logic signed [SB-1:0]          lv_ff, lv_in;
   logic signed [SB-1:0]          tr_ff, tr_in;
   logic signed [SB-1:0]          nt_ff, nt_in;
   logic [A_MAG_BITS-1:0]         a_mag_ff, a_mag_in;
   logic [C_MAG_BITS-1:0]         c_mag_ff, c_mag_in;
   logic                          neg_ff, neg_in;
   logic [PROD_BITS-1:0]          prod_ff, prod_in;
   logic [ACC_BITS-1:0]           acc_ff, acc_in;
   logic [Q_BITS-1:0]             rnd_ff, rnd_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic signed [C_BITS-1:0]   alpha, beta, gain;
   logic signed [A_BITS-1:0]   a_sel, a_abs;
   logic signed [C_BITS-1:0]   c_sel, c_abs;
   logic [A_LO_BITS-1:0]       a_lo;
   logic [A_HI_BITS-1:0]       a_hi;
   logic [ACC_BITS-1:0]        acc_total;
   logic signed [SUM_BITS-1:0] sum_base, rnd_signed;
   logic signed [SB-1:0]       sum_sat;
   logic signed [OUT_BITS-1:0] out_sum;
   logic                       first_term, wet_term;

   assign alpha = C_BITS'(level_coef_ff[COEF_USED-1:0]);
   assign beta  = C_BITS'(trend_coef_ff[COEF_USED-1:0]);
   assign gain  = C_BITS'(boost_gain_ff);
   assign a_lo  = a_mag_ff[A_LO_BITS-1:0];
   assign a_hi  = a_mag_ff[A_MAG_BITS-1:A_LO_BITS];

   assign wet_term   = (cmd.term == chtbb_pkg::TERM_WET);
   assign first_term = (cmd.term == chtbb_pkg::TERM_TREND_DIFF) ||
                       (cmd.term == chtbb_pkg::TERM_LEVEL_IN) || wet_term;

   // operand pick for the current term
   always_comb begin
      unique case (cmd.term)
         chtbb_pkg::TERM_TREND_DIFF: begin
            a_sel = A_BITS'(x_ff) - A_BITS'(lv_ff);
            c_sel = beta;
         end
         chtbb_pkg::TERM_TREND_CARRY: begin
            a_sel = A_BITS'(tr_ff);
            c_sel = K_COEF - beta;
         end
         chtbb_pkg::TERM_LEVEL_IN: begin
            a_sel = A_BITS'(x_ff);
            c_sel = alpha;
         end
         chtbb_pkg::TERM_LEVEL_CARRY: begin
            a_sel = A_BITS'(lv_ff) + A_BITS'(tr_ff);
            c_sel = K_COEF - alpha;
         end
         chtbb_pkg::TERM_WET: begin
            a_sel = A_BITS'(x_ff);
            c_sel = gain;
         end
         default: begin
            a_sel = '0;
            c_sel = '0;
         end
      endcase
      a_abs = a_sel[A_BITS-1] ? -a_sel : a_sel;
      c_abs = c_sel[C_BITS-1] ? -c_sel : c_sel;
   end

   // product recombination, rounding, signed accumulate and saturation
   always_comb begin
      acc_total  = acc_ff + (ACC_BITS'(prod_ff) << A_LO_BITS);
      sum_base   = first_term ? '0 : sum_ff;
      rnd_signed = signed'(SUM_BITS'(rnd_ff));
      if (sum_ff > STATE_MAX) begin
         sum_sat = STATE_MAX[SB-1:0];
      end else if (sum_ff < STATE_MIN) begin
         sum_sat = STATE_MIN[SB-1:0];
      end else begin
         sum_sat = sum_ff[SB-1:0];
      end
      out_sum = OUT_BITS'(dry_ff) + OUT_BITS'(sum_ff);
   end

   // next values of the working registers
   always_comb begin
      level_coef_in = level_coef_ff;
      trend_coef_in = trend_coef_ff;
      boost_gain_in = boost_gain_ff;
      dry_in        = dry_ff;
      x_in          = x_ff;
      lv_in         = lv_ff;
      tr_in         = tr_ff;
      nt_in         = nt_ff;
      a_mag_in      = a_mag_ff;
      c_mag_in      = c_mag_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rnd_in        = rnd_ff;
      sum_in        = sum_ff;
      rsp_data_in   = rsp_data_ff;

      // register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            chtbb_pkg::CSR_LEVEL_COEF: level_coef_in = csr_wdata;
            chtbb_pkg::CSR_TREND_COEF: trend_coef_in = csr_wdata;
            chtbb_pkg::CSR_BOOST_GAIN:
               boost_gain_in = csr_wdata[chtbb_pkg::GAIN_REG_BITS-1:0];
            default: ;
         endcase
      end

      // sample capture, stage 0 input in state format
      if (cmd.load_sample) begin
         dry_in = req_sample_in;
         x_in   = SB'(req_sample_in) <<< EXTRA_FRAC;
      end
      if (cmd.load_state) begin
         lv_in = level_mem_ff[stage_idx];
         tr_in = trend_mem_ff[stage_idx];
      end
      if (cmd.setup) begin
         a_mag_in = a_abs[A_MAG_BITS-1:0];
         c_mag_in = c_abs[C_MAG_BITS-1:0];
         neg_in   = a_sel[A_BITS-1] ^ c_sel[C_BITS-1];
      end
      if (cmd.mul_lo) begin
         prod_in = a_lo * c_mag_ff;
      end
      if (cmd.mul_hi) begin
         prod_in = a_hi * c_mag_ff;
         acc_in  = ACC_BITS'(prod_ff) + (wet_term ? R_WET : R_COEF);
      end
      if (cmd.round) begin
         rnd_in = wet_term ? Q_BITS'(acc_total >> WET_SHIFT)
                           : Q_BITS'(acc_total >> COEF_BITS);
      end
      if (cmd.accum) begin
         sum_in = neg_ff ? sum_base - rnd_signed : sum_base + rnd_signed;
      end
      if (cmd.sat_trend) begin
         nt_in = sum_sat;
      end
      // new level feeds the next stage
      if (cmd.commit) begin
         x_in = sum_sat;
      end
      if (cmd.finish) begin
         if (out_sum > SAMPLE_MAX) begin
            rsp_data_in = SAMPLE_MAX[SAMPLE_BITS-1:0];
         end else if (out_sum < SAMPLE_MIN) begin
            rsp_data_in = SAMPLE_MIN[SAMPLE_BITS-1:0];
         end else begin
            rsp_data_in = out_sum[SAMPLE_BITS-1:0];
         end
      end
   end

   // configuration and stage state, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         level_coef_ff <= '0;
         trend_coef_ff <= '0;
         boost_gain_ff <= '0;
         for (int i = 0; i < STAGES; i++) begin
            level_mem_ff[i] <= '0;
            trend_mem_ff[i] <= '0;
         end
      end else begin
         level_coef_ff <= level_coef_in;
         trend_coef_ff <= trend_coef_in;
         boost_gain_ff <= boost_gain_in;
         if (cmd.commit) begin
            level_mem_ff[stage_idx] <= sum_sat;
            trend_mem_ff[stage_idx] <= nt_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dry_ff      <= dry_in;
      x_ff        <= x_in;
      lv_ff       <= lv_in;
      tr_ff       <= tr_in;
      nt_ff       <= nt_in;
      a_mag_ff    <= a_mag_in;
      c_mag_ff    <= c_mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rnd_ff      <= rnd_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_sample_out = rsp_data_ff;

endmodule

### rtl/cascaded_holt_trend_bass_boost.sv
// top level of the cascaded holt trend bass boost
//
// one signed sample goes in on the req_ channel and one boosted sample comes
// back on the rsp_ channel, both valid/ready. each transfer is run through
// STAGES cascaded level-and-trend smoothers; the last level, scaled by
// boost_gain, is added to the dry sample and saturated.
// all products go through one shared multiplier, split into two partial
// products per term. each term is set up, multiplied in its low and high
// halves, rounded and accumulated; each stage loads its state, works four
// terms, saturates the trend and commits; a wet term follows the last stage.
// req_ready is high only while the sequencer waits for a sample.
// the result sits in an output register; the next sample is taken while it
// waits, and only the final write of a later result holds until it is taken.
// csr_ writes take effect at once; write them while the block is idle.
// synchronous reset clears the coefficients, the gain and all stage state.
module cascaded_holt_trend_bass_boost #(
   parameter int STAGES      = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out,
   input  logic                                 csr_wr_en,
   input  logic [chtbb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [chtbb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int STAGE_IDX_BITS = (STAGES > 1) ? $clog2(STAGES) : 1;

   chtbb_pkg::cmd_type        cmd;
   logic [STAGE_IDX_BITS-1:0] stage_idx;

   // sequencer
   chtbb_ctrl #(
      .STAGES (STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stage_idx (stage_idx)
   );

   // arithmetic and state
   chtbb_datapath #(
      .STAGES      (STAGES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stage_idx      (stage_idx),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

endmodule

### rtl/chtbb_checker.sv
// port-level checks of the bass boost, bound to the top level
module chtbb_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_sample_out
);

   // no result is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // one sample at a time: the block is busy right after an input transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second sample taken while one is in flight");

   // a new result only ends a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a sample in flight");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("stalled result dropped or changed");

endmodule

bind cascaded_holt_trend_bass_boost chtbb_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_chtbb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

### tb/cascaded_holt_trend_bass_boost_tb.sv
// self-checking testbench for the cascaded holt trend bass boost
`timescale 1ns / 1ps

module cascaded_holt_trend_bass_boost_tb;

   localparam int STAGES      = 8;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 24;
   localparam int EXTRA_FRAC  =
      chtbb_pkg::STATE_BITS - SAMPLE_BITS - chtbb_pkg::HEADROOM_BITS;
   localparam int LATENCY     = 23 * STAGES + 7;
   localparam int RANDOM_ITEMS = 1300;
   // margin per sample: busy time, longest idle gap and longest stall, over ~1330 samples, times ~3
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam logic [chtbb_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef logic signed [SAMPLE_BITS-1:0]           sample_type;
   typedef logic signed [chtbb_pkg::STATE_BITS-1:0] stage_word_type;
   typedef logic [chtbb_pkg::CSR_DATA_BITS-1:0]     csr_word_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   // the 0.999 keep factor in coefficient format
   localparam longint KEEP =
      ((longint'(1) <<< COEF_BITS) * chtbb_pkg::KEEP_NUM + chtbb_pkg::KEEP_DEN / 2)
      / chtbb_pkg::KEEP_DEN;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sample_type req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sample_type rsp_sample_out;
   logic csr_wr_en = 1'b0;
   logic [chtbb_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   csr_word_type csr_wdata = '0;

   // predictor state and register copies
   logic [chtbb_pkg::COEF_REG_BITS-1:0] alpha_reg = '0;
   logic [chtbb_pkg::COEF_REG_BITS-1:0] beta_reg = '0;
   logic [chtbb_pkg::GAIN_REG_BITS-1:0] gain_reg = '0;
   stage_word_type smooth_level [STAGES];
   stage_word_type smooth_trend [STAGES];
   sample_type boosted_due [$];

   int idle_pct = 28;
   int stall_left = 0;
   int mismatch_count = 0;
   longint cycle_count = 0;

   cascaded_holt_trend_bass_boost #(
      .STAGES(STAGES),
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF_BITS(COEF_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // product of a state value and a factor, rounded half away from zero
   function automatic longint round_mul(input longint a, input longint c, input int s);
      logic [127:0] ua;
      logic [127:0] uc;
      logic [127:0] prod;
      logic flip;
      flip = (a < 0) != (c < 0);
      ua = (a < 0) ? -a : a;
      uc = (c < 0) ? -c : c;
      prod = ua * uc;
      prod = (prod + (128'd1 << (s - 1))) >> s;
      return flip ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint clip(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // run one sample through the smoother cascade and add the boosted low band
   function automatic sample_type predict_boosted(input sample_type dry_in);
      longint dry;
      longint x;
      longint lv;
      longint tr;
      longint nt;
      longint nl;
      longint alpha;
      longint beta;
      longint wet;
      dry = longint'(dry_in);
      alpha = longint'(alpha_reg);
      beta = longint'(beta_reg);
      x = dry * (longint'(1) <<< EXTRA_FRAC);
      for (int i = 0; i < STAGES; i++) begin
         lv = longint'(smooth_level[i]);
         tr = longint'(smooth_trend[i]);
         nt = round_mul(x - lv, beta, COEF_BITS)
            + round_mul(tr, KEEP - beta, COEF_BITS);
         nl = round_mul(x, alpha, COEF_BITS)
            + round_mul(lv + tr, KEEP - alpha, COEF_BITS);
         smooth_trend[i] = stage_word_type'(clip(nt, chtbb_pkg::STATE_BITS));
         smooth_level[i] = stage_word_type'(clip(nl, chtbb_pkg::STATE_BITS));
         x = longint'(smooth_level[i]);
      end
      wet = round_mul(x, longint'(gain_reg), chtbb_pkg::GAIN_SHIFT + EXTRA_FRAC);
      return sample_type'(clip(dry + wet, SAMPLE_BITS));
   endfunction

   task automatic report_mismatch(input string what, input sample_type got,
                                  input sample_type want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("mismatch at cycle %0d: %s, got %0d want %0d", cycle_count, what, got, want);
   endtask

   // result side: random ready with occasional long stalls
   always @(negedge clock) begin
      if (idle_pct == 0) begin
         stall_left <= 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(999) == 0) begin
         stall_left <= int'($urandom_range(400));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (boosted_due.size() == 0) begin
            report_mismatch("result with no sample pending", rsp_sample_out, '0);
         end else begin
            want = boosted_due.pop_front();
            if (rsp_sample_out !== want)
               report_mismatch("sample_out", rsp_sample_out, want);
         end
      end
   end

   function automatic int pick_gap();
      if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return int'($urandom_range(1, 240));
      return int'($urandom_range(1, 8));
   endfunction

   // one request transfer; valid stays high afterwards until the next call or a drain
   task automatic send_sample(input sample_type s);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      boosted_due.push_back(predict_boosted(s));
   endtask

   task automatic write_csr(input logic [chtbb_pkg::CSR_INDEX_BITS-1:0] idx,
                            input csr_word_type data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         chtbb_pkg::CSR_LEVEL_COEF: alpha_reg = data[chtbb_pkg::COEF_REG_BITS-1:0];
         chtbb_pkg::CSR_TREND_COEF: beta_reg = data[chtbb_pkg::COEF_REG_BITS-1:0];
         chtbb_pkg::CSR_BOOST_GAIN: gain_reg = data[chtbb_pkg::GAIN_REG_BITS-1:0];
         default: ;
      endcase
   endtask

   // drop valid and wait for every pending result
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (boosted_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic csr_word_type pick_coef();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return csr_word_type'(KEEP);
         3: return csr_word_type'(KEEP) + 24'd1 + csr_word_type'($urandom_range(4000));
         4, 5: return csr_word_type'($urandom_range(1, 200000));
         default: return csr_word_type'($urandom());
      endcase
   endfunction

   function automatic csr_word_type pick_gain();
      case ($urandom_range(5))
         0: return '0;
         1: return csr_word_type'(65536);
         2: return csr_word_type'(17'h1FFFF);
         // upper data bits are dropped by the gain register
         3: return csr_word_type'($urandom());
         default: return csr_word_type'($urandom_range(65536));
      endcase
   endfunction

   function automatic sample_type pick_sample(input int n);
      case ($urandom_range(11))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return sample_type'($urandom_range(600)) - sample_type'(300);
         // quarter-rate square wave rings the stages
         4, 5: return n[1] ? SAMPLE_MIN : SAMPLE_MAX;
         default: return sample_type'($urandom());
      endcase
   endfunction

   // all-zero registers after reset pass the dry sample straight through
   task automatic test_reset_state();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(-sample_type'(1));
      send_sample(sample_type'(1));
      wait_drained();
   endtask

   // coefficients at and above the keep factor, gain near two
   task automatic test_coef_extremes();
      write_csr(chtbb_pkg::CSR_LEVEL_COEF, csr_word_type'(KEEP));
      write_csr(chtbb_pkg::CSR_TREND_COEF, csr_word_type'(KEEP) + 24'd1);
      write_csr(chtbb_pkg::CSR_BOOST_GAIN, '1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      wait_drained();
   endtask

   // a write to the unused index must leave every register alone
   task automatic test_unused_index();
      write_csr(CSR_UNUSED, '1);
      write_csr(CSR_UNUSED, csr_word_type'($urandom()));
      send_sample(SAMPLE_MAX);
      send_sample(sample_type'(12345));
      wait_drained();
   endtask

   // resonant setting driven at its peak until the stage state saturates
   task automatic test_runaway_state();
      write_csr(chtbb_pkg::CSR_LEVEL_COEF, '0);
      write_csr(chtbb_pkg::CSR_TREND_COEF, '1);
      write_csr(chtbb_pkg::CSR_BOOST_GAIN, csr_word_type'(65536));
      for (int n = 0; n < 12; n++)
         send_sample(n[1] ? SAMPLE_MIN : SAMPLE_MAX);
      wait_drained();
   endtask

   // phases of random samples under changing register settings
   task automatic test_random_settings();
      int sent;
      int phase;
      int count;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_drained();
         case (phase)
            0: begin
               write_csr(chtbb_pkg::CSR_LEVEL_COEF, '1);
               write_csr(chtbb_pkg::CSR_TREND_COEF, '1);
               write_csr(chtbb_pkg::CSR_BOOST_GAIN, csr_word_type'(17'h1FFFF));
            end
            1: begin
               write_csr(chtbb_pkg::CSR_LEVEL_COEF, '0);
               write_csr(chtbb_pkg::CSR_TREND_COEF, '0);
               write_csr(chtbb_pkg::CSR_BOOST_GAIN, '0);
            end
            default: begin
               if ($urandom_range(4) != 0)
                  write_csr(chtbb_pkg::CSR_LEVEL_COEF, pick_coef());
               if ($urandom_range(4) != 0)
                  write_csr(chtbb_pkg::CSR_TREND_COEF, pick_coef());
               if ($urandom_range(4) != 0)
                  write_csr(chtbb_pkg::CSR_BOOST_GAIN, pick_gain());
               if ($urandom_range(7) == 0)
                  write_csr(CSR_UNUSED, csr_word_type'($urandom()));
            end
         endcase
         // one long stretch with no idling on either side
         idle_pct = (phase == 3) ? 0 : 28;
         count = (phase == 3) ? 150 : int'($urandom_range(40, 120));
         if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
         for (int n = 0; n < count; n++) begin
            send_sample(pick_sample(n));
            sent++;
         end
         phase++;
      end
      idle_pct = 28;
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < STAGES; i++) begin
         smooth_level[i] = '0;
         smooth_trend[i] = '0;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_coef_extremes();
      test_unused_index();
      test_runaway_state();
      test_random_settings();
      // catch any late or extra result
      repeat (2 * LATENCY) @(negedge clock);
      if (mismatch_count == 0 && boosted_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
